>>> design/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Sweep sync pulse decoder package
// Shared widths, codes and structures for the sweep sync pulse decoder.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Width of the free-running edge counter
	localparam int TICK_BITS = 24;
	// Width of every configuration register
	localparam int CFG_W = 24;
	// Width of the tick fields of a result
	localparam int OUT_W = 24;
	// Width of the time stamp
	localparam int TIME_W = 32;
	// Width for sums of up to three tick values and for limits
	localparam int EXT_W = ((TICK_BITS > CFG_W) ? TICK_BITS : CFG_W) + 2;
	// Step counter width of the divider
	localparam int CNT_W = $clog2(TICK_BITS);
	// Configuration index width
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_MIN   = 3'd0,
		REG_SYNC_MAX   = 3'd1,
		REG_AXIS_WIN   = 3'd2,
		REG_PERIOD     = 3'd3,
		REG_TOLERANCE  = 3'd4,
		REG_HIT_MAX    = 3'd5
	} reg_idx_t;

	// Capture phase of the sweep decoder
	typedef enum logic [2:0] {
		PH_UNKNOWN   = 3'd0,
		PH_SYNC      = 3'd1,
		PH_HIT_START = 3'd2,
		PH_HIT_RECV  = 3'd3,
		PH_SWEEP_END = 3'd4
	} phase_t;

	// Sequencer state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_EMIT
	} seq_t;

	// Configuration register set
	typedef struct packed {
		logic [CFG_W-1:0] sync_min;
		logic [CFG_W-1:0] sync_max;
		logic [CFG_W-1:0] axis_win;
		logic [CFG_W-1:0] period;
		logic [CFG_W-1:0] tolerance;
		logic [CFG_W-1:0] hit_max;
	} cfg_t;

	// Status of the shared divider
	typedef struct packed {
		logic busy;
		logic done;
		logic q_lsb;
	} div_stat_t;

endpackage

>>> design/ssd_cfg.sv
// ----------------------------------------------------------------------------
// Sweep sync pulse decoder configuration registers
// Holds the six timing registers, written one at a time by index.
// ----------------------------------------------------------------------------
module ssd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ssd_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [ssd_pkg::CFG_W-1:0]      wr_data,
	output ssd_pkg::cfg_t                  cfg
);

	ssd_pkg::cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_min  <= ssd_pkg::CFG_W'(2500);
			cfg_q.sync_max  <= ssd_pkg::CFG_W'(6500);
			cfg_q.axis_win  <= ssd_pkg::CFG_W'(500);
			cfg_q.period    <= ssd_pkg::CFG_W'(400000);
			cfg_q.tolerance <= ssd_pkg::CFG_W'(3000);
			cfg_q.hit_max   <= ssd_pkg::CFG_W'(1500);
		end else if (wr_en) begin
			unique case (wr_idx)
				ssd_pkg::REG_SYNC_MIN:  cfg_q.sync_min  <= wr_data;
				ssd_pkg::REG_SYNC_MAX:  cfg_q.sync_max  <= wr_data;
				ssd_pkg::REG_AXIS_WIN:  cfg_q.axis_win  <= wr_data;
				ssd_pkg::REG_PERIOD:    cfg_q.period    <= wr_data;
				ssd_pkg::REG_TOLERANCE: cfg_q.tolerance <= wr_data;
				ssd_pkg::REG_HIT_MAX:   cfg_q.hit_max   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/ssd_div.sv
// ----------------------------------------------------------------------------
// Sweep sync pulse decoder divider
// Restoring divider, one quotient bit per cycle, giving the quotient's
// least significant bit used as the sync axis code.
// ----------------------------------------------------------------------------
module ssd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ssd_pkg::TICK_BITS-1:0] dividend,
	input  logic [ssd_pkg::CFG_W-1:0]     divisor,
	output ssd_pkg::div_stat_t            stat
);

	logic                          busy_q;
	logic                          done_q;
	logic                          q_q;
	logic [ssd_pkg::CNT_W-1:0]     cnt_q;
	logic [ssd_pkg::TICK_BITS-1:0] dvd_q;
	logic [ssd_pkg::CFG_W-1:0]     rem_q;
	logic [ssd_pkg::CFG_W:0]       trial;
	logic [ssd_pkg::CFG_W:0]       dsr_ext;
	logic                          fits;

	// Shared compare and subtract step
	assign trial   = {rem_q, dvd_q[ssd_pkg::TICK_BITS-1]};
	assign dsr_ext = {1'b0, divisor};
	assign fits    = (trial >= dsr_ext);

	// Control of the step sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ssd_pkg::CNT_W'(ssd_pkg::TICK_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath: remainder, dividend shift and latest quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ssd_pkg::TICK_BITS-2:0], 1'b0};
			rem_q <= fits ? ssd_pkg::CFG_W'(trial - dsr_ext)
			              : ssd_pkg::CFG_W'(trial);
			q_q   <= fits;
		end
	end

	assign stat.busy  = busy_q;
	assign stat.done  = done_q;
	assign stat.q_lsb = q_q;

endmodule

>>> design/sweep_sync_pulse_decoder.sv
// ----------------------------------------------------------------------------
// Sweep sync pulse decoder
// Decodes optical sweep sync and hit pulse timing from sensor edge stamps.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction carries one sensor edge stamp (edge_ticks) and the
// current time (now_time). The block forms the wrapped tick delta to the
// previous edge and advances its capture phase. When a Y axis sweep
// completes, one output transaction carries both axes' sync width, hit start
// and hit width, stamped with the now_time of the completing edge.
// Configuration writes (cfg_valid, cfg_index, cfg_data) are always taken and
// must only be issued while the block is idle.
// Throughput: one edge at a time. An edge that is not a sync candidate passes
// through evaluation and returns to idle. A sync candidate whose width is
// inside the window runs the shared divider for the axis code, one quotient
// bit per cycle, and waits for the divider to finish. A completing edge
// also passes through the emit state to load the output register.
// Stall: a result waits in the output register; if the next result is due
// before it has been taken, the block holds until out_ready and takes no
// further input transaction meanwhile.
// Reset: all timing registers return to their defaults, the phase returns to
// unknown, the previous edge and all stored pulse values are cleared.
// ----------------------------------------------------------------------------
module sweep_sync_pulse_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ssd_pkg::TICK_BITS-1:0] edge_ticks,
	input  logic [ssd_pkg::TIME_W-1:0]    now_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ssd_pkg::OUT_W-1:0]     x_sync_width,
	output logic [ssd_pkg::OUT_W-1:0]     x_hit_start,
	output logic [ssd_pkg::OUT_W-1:0]     x_hit_width,
	output logic [ssd_pkg::OUT_W-1:0]     y_sync_width,
	output logic [ssd_pkg::OUT_W-1:0]     y_hit_start,
	output logic [ssd_pkg::OUT_W-1:0]     y_hit_width,
	output logic [ssd_pkg::TIME_W-1:0]    cycle_time,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int TB = ssd_pkg::TICK_BITS;
	localparam int EW = ssd_pkg::EXT_W;

	ssd_pkg::cfg_t      cfg;
	ssd_pkg::div_stat_t div_stat;

	ssd_pkg::seq_t   state_q, state_d;
	ssd_pkg::phase_t phase_q, phase_d;
	logic            axis_q, axis_d;
	logic [TB-1:0]   prev_edge_q;
	logic [TB-1:0]   delta_q;
	logic [ssd_pkg::TIME_W-1:0] now_q;
	logic [TB-1:0]   sync_q  [2];
	logic [TB-1:0]   start_q [2];
	logic [TB-1:0]   width_q [2];
	logic            out_valid_q;
	logic [ssd_pkg::OUT_W-1:0]  x_sync_q, x_start_q, x_width_q;
	logic [ssd_pkg::OUT_W-1:0]  y_sync_q, y_start_q, y_width_q;
	logic [ssd_pkg::TIME_W-1:0] cycle_time_q;

	logic                 in_acc;
	logic                 out_load;
	logic                 div_start;
	logic [ssd_pkg::CFG_W-1:0] divisor;
	logic [TB-1:0]        dividend;
	logic [EW-1:0]        delta_ext;
	logic [EW-1:0]        total_sync;
	logic [EW-1:0]        total_hit;
	logic [EW-1:0]        miss_thr;
	logic [EW-1:0]        end_lim;
	logic [EW-1:0]        end_val;
	logic                 end_ok;
	logic                 sync_ok;
	logic                 do_end;
	logic                 tgt_axis;
	logic                 sync_we;
	logic                 sync_idx;
	logic                 hs_we;
	logic [TB-1:0]        hs_val;
	logic                 hw_we;
	logic [TB-1:0]        hw_val;

	// Configuration registers
	ssd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// Shared divider for the sync axis code
	assign divisor  = (cfg.axis_win == '0) ? ssd_pkg::CFG_W'(1) : cfg.axis_win;
	assign dividend = TB'(delta_ext - EW'(cfg.sync_min));

	ssd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (div_stat)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ssd_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (state_q == ssd_pkg::ST_EMIT) && (!out_valid_q || out_ready);

	// Timing sums and limits
	assign delta_ext  = EW'(delta_q);
	assign total_sync = EW'(sync_q[axis_q]) + delta_ext;
	assign total_hit  = EW'(sync_q[axis_q]) + EW'(start_q[axis_q]) + delta_ext;
	assign miss_thr   = (cfg.period > cfg.tolerance)
	                  ? EW'(cfg.period - cfg.tolerance) : '0;
	assign end_lim    = EW'(cfg.period) + EW'(cfg.tolerance);
	assign sync_ok    = (delta_ext >= EW'(cfg.sync_min)) && (delta_ext < EW'(cfg.sync_max));

	// Length that the sweep-end check uses in the current phase
	always_comb begin
		case (phase_q)
			ssd_pkg::PH_SYNC:      end_val = total_sync;
			ssd_pkg::PH_HIT_START: end_val = total_hit;
			default:               end_val = delta_ext;
		endcase
	end
	assign end_ok = (end_val < end_lim);

	// Sequencer and capture phase transitions
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		axis_d    = axis_q;
		div_start = 1'b0;
		do_end    = 1'b0;
		sync_we   = 1'b0;
		sync_idx  = axis_q;
		hs_we     = 1'b0;
		hs_val    = delta_q;
		hw_we     = 1'b0;
		hw_val    = delta_q;
		tgt_axis  = (phase_q == ssd_pkg::PH_SWEEP_END) ? axis_q : 1'b0;
		unique case (state_q)
			ssd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ssd_pkg::ST_EVAL;
				end
			end
			ssd_pkg::ST_EVAL: begin
				state_d = ssd_pkg::ST_IDLE;
				case (phase_q)
					ssd_pkg::PH_SYNC: begin
						if (total_sync >= miss_thr) begin
							// Hit missed altogether
							hs_we  = 1'b1;
							hs_val = '0;
							hw_we  = 1'b1;
							hw_val = '0;
							do_end = 1'b1;
						end else begin
							hs_we   = 1'b1;
							phase_d = ssd_pkg::PH_HIT_START;
						end
					end
					ssd_pkg::PH_HIT_START: begin
						if (delta_ext >= EW'(cfg.hit_max)) begin
							// Hit end missed; the start is kept
							hw_we  = 1'b1;
							hw_val = '0;
							do_end = 1'b1;
						end else begin
							hw_we   = 1'b1;
							phase_d = ssd_pkg::PH_HIT_RECV;
						end
					end
					ssd_pkg::PH_HIT_RECV: begin
						do_end = 1'b1;
					end
					default: begin
						// Sync candidate: the axis code needs the divider
						if (sync_ok) begin
							div_start = 1'b1;
							state_d   = ssd_pkg::ST_DIV;
						end else begin
							phase_d = ssd_pkg::PH_UNKNOWN;
						end
					end
				endcase
				// Sweep-end check shared by the hit phases
				if (do_end) begin
					if (end_ok) begin
						axis_d  = ~axis_q;
						phase_d = ssd_pkg::PH_SWEEP_END;
						if (axis_q) begin
							state_d = ssd_pkg::ST_EMIT;
						end
					end else begin
						phase_d = ssd_pkg::PH_UNKNOWN;
					end
				end
			end
			ssd_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = ssd_pkg::ST_IDLE;
					if (div_stat.q_lsb == tgt_axis) begin
						sync_we  = 1'b1;
						sync_idx = tgt_axis;
						axis_d   = tgt_axis;
						phase_d  = ssd_pkg::PH_SYNC;
					end else begin
						phase_d = ssd_pkg::PH_UNKNOWN;
					end
				end
			end
			ssd_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ssd_pkg::ST_IDLE;
				end
			end
			default: state_d = ssd_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssd_pkg::ST_IDLE;
			phase_q     <= ssd_pkg::PH_UNKNOWN;
			axis_q      <= 1'b0;
			prev_edge_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			axis_q  <= axis_d;
			if (in_acc) begin
				prev_edge_q <= edge_ticks;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pulse stores, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				sync_q[i]  <= '0;
				start_q[i] <= '0;
				width_q[i] <= '0;
			end
		end else begin
			if (sync_we) begin
				sync_q[sync_idx] <= delta_q;
			end
			if (hs_we) begin
				start_q[axis_q] <= hs_val;
			end
			if (hw_we) begin
				width_q[axis_q] <= hw_val;
			end
		end
	end

	// Accepted edge and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			delta_q <= edge_ticks - prev_edge_q;
			now_q   <= now_time;
		end
		if (out_load) begin
			x_sync_q     <= ssd_pkg::OUT_W'(sync_q[0]);
			x_start_q    <= ssd_pkg::OUT_W'(start_q[0]);
			x_width_q    <= ssd_pkg::OUT_W'(width_q[0]);
			y_sync_q     <= ssd_pkg::OUT_W'(sync_q[1]);
			y_start_q    <= ssd_pkg::OUT_W'(start_q[1]);
			y_width_q    <= ssd_pkg::OUT_W'(width_q[1]);
			cycle_time_q <= now_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign x_sync_width = x_sync_q;
	assign x_hit_start  = x_start_q;
	assign x_hit_width  = x_width_q;
	assign y_sync_width = y_sync_q;
	assign y_hit_start  = y_start_q;
	assign y_hit_width  = y_width_q;
	assign cycle_time   = cycle_time_q;

`ifndef ASSERT_OFF
	// The divider is at work for as long as the sequencer waits on it.
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssd_pkg::ST_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle divider");

	// An accepted edge is evaluated in the next cycle.
	a_eval_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ssd_pkg::ST_EVAL))
		else $error("accepted edge not evaluated");

	// A result appears only once both axes are done and the X axis is next.
	a_result_axis: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (!axis_q && (phase_q == ssd_pkg::PH_SWEEP_END)))
		else $error("result outside a completed Y axis sweep");
`endif

endmodule
